>>> rtl/tffp_pkg.sv
// ============================================================================
// tffp_pkg
// Shared types, character codes, field codes and the key table of the
// tab-separated telemetry frame parser.
// ============================================================================
`default_nettype none

package tffp_pkg;

    localparam int TEXT_CHARS = 8;
    localparam int KEY_COUNT  = 18;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_HI = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_UO    = 8'h4F;
    localparam logic [7:0] CH_UN    = 8'h4E;

    localparam logic [4:0] FID_NONE = 5'd0;
    localparam logic [4:0] FID_PID  = 5'd1;
    localparam logic [4:0] FID_SER  = 5'd3;
    localparam logic [4:0] FID_LOAD = 5'd11;
    localparam logic [4:0] FID_CSUM = 5'd18;
    localparam logic [4:0] FID_MAX  = 5'd18;

    localparam logic [1:0] MODE_DEC  = 2'd0;
    localparam logic [1:0] MODE_ZERO = 2'd1;
    localparam logic [1:0] MODE_HEX  = 2'd2;
    localparam logic [1:0] MODE_STOP = 2'd3;

    localparam logic [32:0] ACC_CAP = 33'h1_0000_0000 >> 1;

    localparam logic [63:0] KEY_VAL [KEY_COUNT] = '{
        64'h0000_0000_0050_4944, 64'h0000_0000_0000_4657,
        64'h0000_0000_5345_5223, 64'h0000_0000_0000_0056,
        64'h0000_0000_0000_0049, 64'h0000_0000_0000_494C,
        64'h0000_0000_0056_5056, 64'h0000_0000_0050_5056,
        64'h0000_0000_0000_4353, 64'h0000_0000_0045_5252,
        64'h0000_0000_4C4F_4144, 64'h0000_0000_0048_3139,
        64'h0000_0000_0048_3230, 64'h0000_0000_0048_3232,
        64'h0000_0000_0048_3231, 64'h0000_0000_0048_3233,
        64'h0000_0000_4853_4453, 64'h4368_6563_6B73_756D
    };

    localparam logic [3:0] KEY_LEN [KEY_COUNT] = '{
        4'd3, 4'd2, 4'd4, 4'd1, 4'd1, 4'd2, 4'd3, 4'd3, 4'd2,
        4'd3, 4'd4, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd4, 4'd8
    };

    typedef struct packed {
        logic [4:0]         field_id;
        logic signed [31:0] numeric_value;
        logic [63:0]        text_value;
        logic               block_end;
        logic               checksum_ok;
    } t_record;

    function automatic logic [4:0] find_key(input logic [63:0] key, input logic [3:0] len);
        logic [4:0] id;
        id = FID_NONE;
        for (int k = 0; k < KEY_COUNT; k++) begin
            if (len == KEY_LEN[k] && key == KEY_VAL[k]) begin
                id = 5'(k + 1);
            end
        end
        return id;
    endfunction

endpackage

`default_nettype wire

>>> rtl/tffp_core.sv
// ============================================================================
// tffp_core
// Line state of the parser: key capture, value parsing, text capture and the
// block byte sum. One character is consumed per step.
// ============================================================================
`default_nettype none

module tffp_core
    import tffp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    output logic            o_emit,
    output t_record         o_rec
);

    logic [63:0] r_key_shift, n_key_shift;
    logic [3:0]  r_key_len,   n_key_len;
    logic        r_in_value,  n_in_value;
    logic [4:0]  r_fid,       n_fid;
    logic [32:0] r_acc,       n_acc;
    logic        r_neg,       n_neg;
    logic [1:0]  r_mode,      n_mode;
    logic [63:0] r_text,      n_text;
    logic [3:0]  r_tcount,    n_tcount;
    logic [7:0]  r_block_sum, n_block_sum;
    logic        r_in_block,  n_in_block;
    logic [7:0]  r_line_sum,  n_line_sum;

    logic [7:0]  line_sum_new;
    logic [7:0]  block_sum_add;
    logic [63:0] text_put;
    logic [3:0]  tcount_inc;
    logic        is_dec;
    logic        is_hex;
    logic [3:0]  hex_val;
    logic [36:0] acc_x10;
    logic [36:0] acc_x16;
    logic [36:0] acc_dec;
    logic [36:0] acc_hex;
    logic [32:0] acc_dec_cap;
    logic [32:0] acc_hex_cap;
    logic        csum_raw;

    assign line_sum_new  = r_line_sum + i_byte;
    assign block_sum_add = r_block_sum + line_sum_new;
    assign tcount_inc    = (r_tcount == 4'hF) ? r_tcount : r_tcount + 4'd1;
    assign csum_raw      = (r_fid == FID_CSUM) && (r_tcount == 4'd0);

    always_comb begin
        text_put = r_text;
        for (int i = 0; i < 8; i++) begin
            if (i < TEXT_CHARS && r_tcount == 4'(i)) begin
                text_put[63 - 8 * i -: 8] = r_text[63 - 8 * i -: 8] | i_byte;
            end
        end
    end

    always_comb begin
        is_dec  = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
        is_hex  = 1'b1;
        hex_val = 4'd0;
        if (is_dec) begin
            hex_val = 4'(i_byte - CH_ZERO);
        end else if (i_byte >= CH_LA && i_byte <= CH_LF_HI) begin
            hex_val = 4'(i_byte - CH_LA + 8'd10);
        end else if (i_byte >= CH_UA && i_byte <= CH_UF) begin
            hex_val = 4'(i_byte - CH_UA + 8'd10);
        end else begin
            is_hex = 1'b0;
        end
    end

    assign acc_x10     = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0};
    assign acc_x16     = {r_acc, 4'b0000};
    assign acc_dec     = acc_x10 + {33'd0, hex_val};
    assign acc_hex     = acc_x16 + {33'd0, hex_val};
    assign acc_dec_cap = (acc_dec > {4'd0, ACC_CAP}) ? ACC_CAP : acc_dec[32:0];
    assign acc_hex_cap = (acc_hex > {4'd0, ACC_CAP}) ? ACC_CAP : acc_hex[32:0];

    always_comb begin
        n_key_shift = r_key_shift;
        n_key_len   = r_key_len;
        n_in_value  = r_in_value;
        n_fid       = r_fid;
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_mode      = r_mode;
        n_text      = r_text;
        n_tcount    = r_tcount;
        n_block_sum = r_block_sum;
        n_in_block  = r_in_block;
        n_line_sum  = line_sum_new;
        o_emit      = 1'b0;
        o_rec       = '0;

        priority if (csum_raw) begin
            n_acc    = {25'd0, i_byte};
            n_mode   = MODE_STOP;
            n_text   = text_put;
            n_tcount = tcount_inc;
        end else if (i_byte == CH_LF) begin
            o_emit         = 1'b1;
            o_rec.field_id = r_fid;
            if (r_fid == FID_LOAD) begin
                o_rec.numeric_value = (r_mode == MODE_HEX) ? 32'sd1 : 32'sd0;
            end else if (r_fid == FID_CSUM) begin
                o_rec.numeric_value = {24'd0, r_acc[7:0]};
            end else if (r_fid != FID_NONE && r_fid != FID_SER) begin
                if (r_neg) begin
                    o_rec.numeric_value = 32'd0 - r_acc[31:0];
                end else if (|r_acc[32:31]) begin
                    o_rec.numeric_value = 32'h7FFF_FFFF;
                end else begin
                    o_rec.numeric_value = r_acc[31:0];
                end
            end
            o_rec.text_value = r_in_value ? r_text : 64'd0;
            if (r_fid == FID_PID) begin
                n_block_sum = line_sum_new;
                n_in_block  = 1'b1;
            end else if (r_in_block) begin
                n_block_sum = block_sum_add;
                if (r_fid == FID_CSUM) begin
                    o_rec.block_end   = 1'b1;
                    o_rec.checksum_ok = (block_sum_add == 8'd0);
                    n_in_block        = 1'b0;
                    n_block_sum       = 8'd0;
                end
            end
            n_key_shift = '0;
            n_key_len   = '0;
            n_in_value  = 1'b0;
            n_fid       = FID_NONE;
            n_acc       = '0;
            n_neg       = 1'b0;
            n_mode      = MODE_DEC;
            n_text      = '0;
            n_tcount    = '0;
            n_line_sum  = '0;
        end else if (i_byte == CH_CR) begin
            n_line_sum = line_sum_new;
        end else if (!r_in_value) begin
            if (i_byte == CH_TAB) begin
                n_in_value = 1'b1;
                n_fid      = find_key(r_key_shift, r_key_len);
            end else begin
                if (r_key_len < 4'd8) begin
                    n_key_shift = {r_key_shift[55:0], i_byte};
                end
                if (r_key_len != 4'hF) begin
                    n_key_len = r_key_len + 4'd1;
                end
            end
        end else begin
            n_text   = text_put;
            n_tcount = tcount_inc;
            if (r_fid == FID_LOAD) begin
                if (r_mode == MODE_DEC) begin
                    n_mode = (i_byte == CH_UO) ? MODE_ZERO : MODE_STOP;
                end else if (r_mode == MODE_ZERO) begin
                    n_mode = (i_byte == CH_UN) ? MODE_HEX : MODE_STOP;
                end
            end else if (r_fid != FID_NONE && r_fid != FID_SER && r_fid != FID_CSUM) begin
                priority if (r_mode == MODE_STOP) begin
                    n_mode = MODE_STOP;
                end else if (r_tcount == 4'd0 && (i_byte == CH_MINUS || i_byte == CH_PLUS)) begin
                    n_neg = (i_byte == CH_MINUS);
                end else if (r_mode == MODE_HEX) begin
                    if (is_hex) begin
                        n_acc = acc_hex_cap;
                    end else begin
                        n_mode = MODE_STOP;
                    end
                end else if (r_mode == MODE_ZERO && r_tcount == 4'd1
                             && (i_byte == CH_LX || i_byte == CH_UX)) begin
                    n_mode = MODE_HEX;
                end else if (is_dec) begin
                    n_acc  = acc_dec_cap;
                    n_mode = (r_fid == FID_PID && r_tcount == 4'd0 && i_byte == CH_ZERO)
                             ? MODE_ZERO : MODE_DEC;
                end else begin
                    n_mode = MODE_STOP;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_shift <= '0;
            r_key_len   <= '0;
            r_in_value  <= 1'b0;
            r_fid       <= FID_NONE;
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_mode      <= MODE_DEC;
            r_text      <= '0;
            r_tcount    <= '0;
            r_block_sum <= '0;
            r_in_block  <= 1'b0;
            r_line_sum  <= '0;
        end else if (i_step) begin
            r_key_shift <= n_key_shift;
            r_key_len   <= n_key_len;
            r_in_value  <= n_in_value;
            r_fid       <= n_fid;
            r_acc       <= n_acc;
            r_neg       <= n_neg;
            r_mode      <= n_mode;
            r_text      <= n_text;
            r_tcount    <= n_tcount;
            r_block_sum <= n_block_sum;
            r_in_block  <= n_in_block;
            r_line_sum  <= n_line_sum;
        end
    end

endmodule

`default_nettype wire

>>> rtl/text_frame_field_parser.sv
// ============================================================================
// text_frame_field_parser
// Each character is held in the input register; the record of a newline is then
// registered. One character per cycle; a newline stalls while a record waits.
// Reset clears the line state, the block sum and both handshake registers.
// ============================================================================
`default_nettype none

module text_frame_field_parser
    import tffp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_rx_valid,
    output logic             o_rx_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_rec_valid,
    input  wire logic        i_rec_ready,
    output logic [4:0]       o_field_id,
    output logic signed [31:0] o_numeric_value,
    output logic [63:0]      o_text_value,
    output logic             o_block_end,
    output logic             o_checksum_ok
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_record    r_out_rec;
    logic       w_emit;
    t_record    w_rec;
    logic       w_step;

    assign w_step     = r_in_valid && (!w_emit || !r_out_valid || i_rec_ready);
    assign o_rx_ready = !r_in_valid || w_step;

    tffp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_byte  (r_in_byte),
        .o_emit  (w_emit),
        .o_rec   (w_rec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_rx_ready) begin
                r_in_valid <= i_rx_valid;
            end
            if (w_step && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_rec_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
        if (w_step && w_emit) begin
            r_out_rec <= w_rec;
        end
    end

    assign o_rec_valid     = r_out_valid;
    assign o_field_id      = r_out_rec.field_id;
    assign o_numeric_value = r_out_rec.numeric_value;
    assign o_text_value    = r_out_rec.text_value;
    assign o_block_end     = r_out_rec.block_end;
    assign o_checksum_ok   = r_out_rec.checksum_ok;

endmodule

`default_nettype wire

>>> rtl/tffp_checker.sv
// ============================================================================
// tffp_checker
// Port-level checks on the record channel of the frame parser.
// ============================================================================
`default_nettype none

module tffp_checker
    import tffp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        o_rec_valid,
    input  wire logic        i_rec_ready,
    input  wire logic [4:0]  o_field_id,
    input  wire logic [31:0] o_numeric_value,
    input  wire logic        o_block_end,
    input  wire logic        o_checksum_ok
);

    a_ok_needs_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rec_valid && o_checksum_ok |-> o_block_end)
        else $error("checksum_ok without block_end");

    a_end_is_csum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rec_valid && o_block_end |-> o_field_id == FID_CSUM)
        else $error("block_end on a line that is not Checksum");

    a_load_bool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rec_valid && o_field_id == FID_LOAD |-> o_numeric_value[31:1] == 31'd0)
        else $error("LOAD value is not 0 or 1");

    a_id_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rec_valid |-> o_field_id <= FID_MAX)
        else $error("field_id out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rec_valid && !i_rec_ready |=> o_rec_valid && $stable(o_field_id))
        else $error("record dropped while stalled");

endmodule

bind text_frame_field_parser tffp_checker u_tffp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_rec_valid     (o_rec_valid),
    .i_rec_ready     (i_rec_ready),
    .o_field_id      (o_field_id),
    .o_numeric_value (o_numeric_value),
    .o_block_end     (o_block_end),
    .o_checksum_ok   (o_checksum_ok)
);

`default_nettype wire
